>>> hdl/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types, codes and constants of the command frame decoder.
// ----------------------------------------------------------------------------
package cfd_pkg;

  // frame layout bytes
  localparam logic [7:0] HdrByte  = 8'hAA;
  localparam logic [7:0] TypeGain = 8'h02;
  localparam logic [7:0] TypeDir  = 8'h03;

  // frame kind codes as reported on the result side
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_GAIN  = 2'd1;
  localparam logic [1:0] KIND_DIR   = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  // gain update subcommands
  localparam logic [7:0] SUB_GAIN_P     = 8'h01;
  localparam logic [7:0] SUB_GAIN_I     = 8'h02;
  localparam logic [7:0] SUB_GAIN_D     = 8'h03;
  localparam logic [7:0] SUB_GAIN_WHEEL = 8'h04;
  localparam logic [7:0] SUB_GAIN_SCALE = 8'h05;

  // direction subcommands
  localparam logic [7:0] SUB_DIR_HALT     = 8'h00;
  localparam logic [7:0] SUB_DIR_BACK     = 8'h01;
  localparam logic [7:0] SUB_DIR_FWD      = 8'h02;
  localparam logic [7:0] SUB_DIR_LEFT     = 8'h03;
  localparam logic [7:0] SUB_DIR_RIGHT    = 8'h04;
  localparam logic [7:0] SUB_DIR_TRIM_UP  = 8'h05;
  localparam logic [7:0] SUB_DIR_TRIM_DN  = 8'h06;
  localparam logic [7:0] SUB_DIR_START    = 8'h07;
  localparam logic [7:0] SUB_DIR_STOP     = 8'h08;

  // trim saturation limits
  localparam logic signed [15:0] TrimMax = 16'sh7FFF;
  localparam logic signed [15:0] TrimMin = 16'sh8000;

  // floor(x / 100) for any 32-bit x is (x * RecipHundred) >> RecipShift
  localparam logic [31:0] RecipHundred = 32'h51EB_851F;
  localparam int unsigned RecipShift   = 37;

  // queue depth on both sides of the back end
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // classified frame handed from front to back
  typedef struct packed {
    logic        ok;
    logic [1:0]  kind;
    logic [7:0]  sub;
    logic [15:0] value;
  } cmd_t;

  // architectural state reported with every result
  typedef struct packed {
    logic signed [8:0]  speed;
    logic signed [8:0]  turn;
    logic signed [15:0] trim;
    logic [25:0]        gain_p;
    logic [25:0]        gain_i;
    logic [25:0]        gain_d;
    logic [15:0]        wheel_gain;
    logic [15:0]        gain_scale;
    logic               running;
  } state_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] kind;
    state_t     state;
  } result_t;

  localparam state_t StateReset = '{
    speed:      9'sd0,
    turn:       9'sd0,
    trim:       16'sd0,
    gain_p:     26'd4000,
    gain_i:     26'd500,
    gain_d:     26'd40,
    wheel_gain: 16'd1500,
    gain_scale: 16'd100,
    running:    1'b0
  };

endpackage

>>> hdl/cfd_front.sv
// ----------------------------------------------------------------------------
// cfd_front
// Byte window, header and check match, frame classification and the short
// command queue towards the back end.
// ----------------------------------------------------------------------------
module cfd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        rx_byte_i,
  output logic              cmd_valid_o,
  output cfd_pkg::cmd_t     cmd_o,
  input  logic              cmd_pop_i
);

  logic [7:0] win_q [5];
  logic       cmd_push;
  logic       match;
  cfd_pkg::cmd_t cmd_new;

  cfd_pkg::cmd_t                   cmd_mem [cfd_pkg::QueueDepth];
  logic [cfd_pkg::QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [cfd_pkg::QueueCntW-1:0]   cnt_q, cnt_d;

  assign full     = (cnt_q == cfd_pkg::QueueCntW'(cfd_pkg::QueueDepth));
  assign cmd_push = push && !full;

  // header and check byte match against the incoming byte
  assign match = (win_q[4] == cfd_pkg::HdrByte) &&
                 ((win_q[0] ^ win_q[1] ^ win_q[2]) == rx_byte_i);

  // classify the window
  always_comb begin
    cmd_new.ok    = match;
    cmd_new.sub   = win_q[2];
    cmd_new.value = {win_q[1], win_q[0]};
    if (!match) begin
      cmd_new.kind = cfd_pkg::KIND_NONE;
    end else if (win_q[3] == cfd_pkg::TypeGain) begin
      cmd_new.kind = cfd_pkg::KIND_GAIN;
    end else if (win_q[3] == cfd_pkg::TypeDir) begin
      cmd_new.kind = cfd_pkg::KIND_DIR;
    end else begin
      cmd_new.kind = cfd_pkg::KIND_OTHER;
    end
  end

  // window shift on every transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) win_q[i] <= 8'h00;
    end else if (cmd_push) begin
      win_q[0] <= rx_byte_i;
      for (int i = 1; i < 5; i++) win_q[i] <= win_q[i-1];
    end
  end

  // command queue storage
  always_ff @(posedge clk_i) begin
    if (cmd_push) begin
      cmd_mem[wr_ptr_q] <= cmd_new;
    end
  end

  // queue occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_push && !cmd_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!cmd_push && cmd_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_push)  wr_ptr_q <= wr_ptr_q + 1'b1;
      if (cmd_pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = cmd_mem[rd_ptr_q];

  // checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cfd_pkg::QueueCntW'(cfd_pkg::QueueDepth))
    else $error("command queue overfilled");

  a_window_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |=> (win_q[0] == $past(rx_byte_i)))
    else $error("window did not take the transferred byte");

  a_ok_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> (cmd_new.ok == (cmd_new.kind != cfd_pkg::KIND_NONE)))
    else $error("frame kind disagrees with match flag");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cmd_valid_o)
    else $error("command queue popped while empty");

endmodule

>>> hdl/cfd_back.sv
// ----------------------------------------------------------------------------
// cfd_back
// Executes classified frames in two stages (gain product, then divide by
// one hundred and state update) and queues one state snapshot per byte.
// ----------------------------------------------------------------------------
module cfd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  cfd_pkg::cmd_t     cmd_i,
  output logic              cmd_pop_o,
  output logic              empty,
  input  logic              pop,
  output cfd_pkg::result_t  result_o
);

  logic          advance;
  logic          res_push, res_pop;

  // scale as seen by commands entering the product stage
  logic [15:0]   scale_fwd_q;

  // product stage registers
  logic          b_valid_q;
  cfd_pkg::cmd_t b_cmd_q;
  logic [31:0]   b_prod_q;

  // state and its update
  cfd_pkg::state_t st_q, st_d;
  logic [63:0]     recip_prod;
  logic [25:0]     quot;

  // result queue
  cfd_pkg::result_t                res_mem [cfd_pkg::QueueDepth];
  logic [cfd_pkg::QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [cfd_pkg::QueueCntW-1:0]   cnt_q, cnt_d;

  assign advance   = (cnt_q != cfd_pkg::QueueCntW'(cfd_pkg::QueueDepth));
  assign cmd_pop_o = advance && cmd_valid_i;
  assign res_push  = advance && b_valid_q;
  assign res_pop   = pop && !empty;

  // product stage: scale times value, scale updates take effect here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      scale_fwd_q <= cfd_pkg::StateReset.gain_scale;
    end else if (advance) begin
      b_valid_q <= cmd_valid_i;
      if (cmd_valid_i && cmd_i.kind == cfd_pkg::KIND_GAIN &&
          cmd_i.sub == cfd_pkg::SUB_GAIN_SCALE) begin
        scale_fwd_q <= cmd_i.value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      b_cmd_q  <= cmd_i;
      b_prod_q <= {16'h0000, scale_fwd_q} * {16'h0000, cmd_i.value};
    end
  end

  // divide by one hundred through the reciprocal
  assign recip_prod = {32'h0, b_prod_q} * {32'h0, cfd_pkg::RecipHundred};
  assign quot       = recip_prod[cfd_pkg::RecipShift +: 26];

  // state update
  always_comb begin
    st_d = st_q;
    if (b_cmd_q.kind == cfd_pkg::KIND_GAIN) begin
      unique case (b_cmd_q.sub)
        cfd_pkg::SUB_GAIN_P:     st_d.gain_p     = quot;
        cfd_pkg::SUB_GAIN_I:     st_d.gain_i     = quot;
        cfd_pkg::SUB_GAIN_D:     st_d.gain_d     = quot;
        cfd_pkg::SUB_GAIN_WHEEL: st_d.wheel_gain = b_cmd_q.value;
        cfd_pkg::SUB_GAIN_SCALE: st_d.gain_scale = b_cmd_q.value;
        default: ;
      endcase
    end else if (b_cmd_q.kind == cfd_pkg::KIND_DIR) begin
      unique case (b_cmd_q.sub)
        cfd_pkg::SUB_DIR_HALT: begin
          st_d.speed = 9'sd0;
          st_d.turn  = 9'sd0;
        end
        cfd_pkg::SUB_DIR_BACK:  st_d.speed = -$signed({1'b0, b_cmd_q.value[7:0]});
        cfd_pkg::SUB_DIR_FWD:   st_d.speed = $signed({1'b0, b_cmd_q.value[7:0]});
        cfd_pkg::SUB_DIR_LEFT:  st_d.turn  = $signed({1'b0, b_cmd_q.value[7:0]});
        cfd_pkg::SUB_DIR_RIGHT: st_d.turn  = -$signed({1'b0, b_cmd_q.value[7:0]});
        cfd_pkg::SUB_DIR_TRIM_UP: begin
          if (st_q.trim != cfd_pkg::TrimMax) st_d.trim = st_q.trim + 16'sd1;
        end
        cfd_pkg::SUB_DIR_TRIM_DN: begin
          if (st_q.trim != cfd_pkg::TrimMin) st_d.trim = st_q.trim - 16'sd1;
        end
        cfd_pkg::SUB_DIR_START: begin
          st_d.running = 1'b1;
          st_d.speed   = 9'sd0;
          st_d.turn    = 9'sd0;
        end
        cfd_pkg::SUB_DIR_STOP: begin
          st_d.running = 1'b0;
          st_d.speed   = 9'sd0;
          st_d.turn    = 9'sd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= cfd_pkg::StateReset;
    end else if (res_push) begin
      st_q <= st_d;
    end
  end

  // result queue storage, one snapshot per byte
  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_mem[wr_ptr_q] <= '{ok: b_cmd_q.ok, kind: b_cmd_q.kind, state: st_d};
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (res_push && !res_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!res_push && res_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (res_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (res_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  assign empty    = (cnt_q == '0);
  assign result_o = res_mem[rd_ptr_q];

  // checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cfd_pkg::QueueCntW'(cfd_pkg::QueueDepth))
    else $error("result queue overfilled");

  a_scale_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !b_valid_q |-> (scale_fwd_q == st_q.gain_scale))
    else $error("forwarded scale out of step with state");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(b_valid_q) && $stable(b_prod_q) && $stable(st_q)))
    else $error("product stage moved during a stall");

endmodule

>>> hdl/command_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// command_frame_decoder_unit
// Serial command frame decoder: slides a six-byte window over received
// bytes, checks header and XOR, and applies gain and direction commands.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------------
//   bytes    | in        | push / full        | rx_byte_i
//   results  | out       | empty / pop        | frame_ok_o .. running_o
//
// One byte per cycle while full stays low; each byte gives exactly one
// result. A byte transfer writes the command queue, the product stage
// (scale times value) then registers the command, and the divide-by-100
// and state update write the result queue from the product stage.
// Two-entry queues sit before and after the execute stages; when the
// result queue is full the execute stages hold and full rises once the
// command queue fills. Reset restores the window and the default gains.
// ----------------------------------------------------------------------------
module command_frame_decoder_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic               frame_ok_o,
  output logic [1:0]         frame_kind_o,
  output logic signed [8:0]  speed_demand_o,
  output logic signed [8:0]  turn_demand_o,
  output logic signed [15:0] trim_tenths_o,
  output logic [25:0]        gain_p_o,
  output logic [25:0]        gain_i_o,
  output logic [25:0]        gain_d_o,
  output logic [15:0]        wheel_gain_o,
  output logic [15:0]        gain_scale_o,
  output logic               running_o
);

  logic             cmd_valid;
  logic             cmd_pop;
  cfd_pkg::cmd_t    cmd;
  cfd_pkg::result_t result;

  // front end: window and classification
  cfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .rx_byte_i   (rx_byte_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // back end: execution and result queue
  cfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result)
  );

  // result fields
  assign frame_ok_o     = result.ok;
  assign frame_kind_o   = result.kind;
  assign speed_demand_o = result.state.speed;
  assign turn_demand_o  = result.state.turn;
  assign trim_tenths_o  = result.state.trim;
  assign gain_p_o       = result.state.gain_p;
  assign gain_i_o       = result.state.gain_i;
  assign gain_d_o       = result.state.gain_d;
  assign wheel_gain_o   = result.state.wheel_gain;
  assign gain_scale_o   = result.state.gain_scale;
  assign running_o      = result.state.running;

endmodule

>>> tb/command_frame_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// command_frame_decoder_unit_tb
// Self-checking bench for the command frame decoder. Received bytes go in
// through the push/full side with random bursts and gaps; every status
// result comes back through the empty/pop side under its own stall pattern
// and is compared field by field with a cycle-free model of the decoder.
// Stimulus runs from directed frames to random frame streams, then chained
// trim frames that share their header and check bytes.
// ----------------------------------------------------------------------------
module command_frame_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfd_pkg::*;

  localparam int unsigned CycleLimit = 50_000;
  localparam int unsigned DrainCycles = 10;

  // frame type outside gain and direction, and an unused subcommand
  localparam logic [7:0] TypeOther  = 8'h07;
  localparam logic [7:0] SubUnknown = 8'h0F;

  typedef struct {
    logic [7:0] data;
    bit         fast;
  } rx_item_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [7:0]         rx_byte_i = 8'h00;
  logic               empty;
  logic               pop = 1'b0;
  logic               frame_ok_o;
  logic [1:0]         frame_kind_o;
  logic signed [8:0]  speed_demand_o;
  logic signed [8:0]  turn_demand_o;
  logic signed [15:0] trim_tenths_o;
  logic [25:0]        gain_p_o;
  logic [25:0]        gain_i_o;
  logic [25:0]        gain_d_o;
  logic [15:0]        wheel_gain_o;
  logic [15:0]        gain_scale_o;
  logic               running_o;

  // bytes still to send, status reports still to arrive
  rx_item_t  rx_backlog[$];
  result_t   status_reports[$];

  // decoder model: byte window (index 0 newest) and architectural state
  logic [4:0][7:0] recent_rx;
  state_t          dec_state;

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  bit          fast_mode = 1'b0;
  rx_item_t    next_item;

  command_frame_decoder_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .rx_byte_i      (rx_byte_i),
    .empty          (empty),
    .pop            (pop),
    .frame_ok_o     (frame_ok_o),
    .frame_kind_o   (frame_kind_o),
    .speed_demand_o (speed_demand_o),
    .turn_demand_o  (turn_demand_o),
    .trim_tenths_o  (trim_tenths_o),
    .gain_p_o       (gain_p_o),
    .gain_i_o       (gain_i_o),
    .gain_d_o       (gain_d_o),
    .wheel_gain_o   (wheel_gain_o),
    .gain_scale_o   (gain_scale_o),
    .running_o      (running_o)
  );

  // scale times value over 100, rounded down, kept to 26 bits
  function automatic logic [25:0] scaled_gain(input logic [15:0] scale,
                                              input logic [15:0] value);
    logic [63:0] product;
    product = 64'(scale) * 64'(value);
    product = product / 64'd100;
    return product[25:0];
  endfunction

  // advance the model by one received byte and queue the status it reports
  task automatic decode_rx_byte(input logic [7:0] rx);
    logic [7:0]  lo, hi, sub, ftype, hdr;
    logic [15:0] value;
    result_t     res;
    lo    = recent_rx[0];
    hi    = recent_rx[1];
    sub   = recent_rx[2];
    ftype = recent_rx[3];
    hdr   = recent_rx[4];
    recent_rx = {recent_rx[3:0], rx};
    res.ok   = 1'b0;
    res.kind = KIND_NONE;
    if (hdr == HdrByte && (lo ^ hi ^ sub) == rx) begin
      res.ok = 1'b1;
      value  = {hi, lo};
      if (ftype == TypeGain) begin
        res.kind = KIND_GAIN;
        case (sub)
          SUB_GAIN_P:     dec_state.gain_p = scaled_gain(dec_state.gain_scale, value);
          SUB_GAIN_I:     dec_state.gain_i = scaled_gain(dec_state.gain_scale, value);
          SUB_GAIN_D:     dec_state.gain_d = scaled_gain(dec_state.gain_scale, value);
          SUB_GAIN_WHEEL: dec_state.wheel_gain = value;
          SUB_GAIN_SCALE: dec_state.gain_scale = value;
          default: ;
        endcase
      end else if (ftype == TypeDir) begin
        res.kind = KIND_DIR;
        case (sub)
          SUB_DIR_HALT: begin
            dec_state.speed = '0;
            dec_state.turn  = '0;
          end
          SUB_DIR_BACK:  dec_state.speed = -$signed({1'b0, lo});
          SUB_DIR_FWD:   dec_state.speed = $signed({1'b0, lo});
          SUB_DIR_LEFT:  dec_state.turn  = $signed({1'b0, lo});
          SUB_DIR_RIGHT: dec_state.turn  = -$signed({1'b0, lo});
          SUB_DIR_TRIM_UP: begin
            if (dec_state.trim != TrimMax) dec_state.trim = dec_state.trim + 16'sd1;
          end
          SUB_DIR_TRIM_DN: begin
            if (dec_state.trim != TrimMin) dec_state.trim = dec_state.trim - 16'sd1;
          end
          SUB_DIR_START: begin
            dec_state.running = 1'b1;
            dec_state.speed   = '0;
            dec_state.turn    = '0;
          end
          SUB_DIR_STOP: begin
            dec_state.running = 1'b0;
            dec_state.speed   = '0;
            dec_state.turn    = '0;
          end
          default: ;
        endcase
      end else begin
        res.kind = KIND_OTHER;
      end
    end
    res.state = dec_state;
    status_reports.push_back(res);
  endtask

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // stimulus helpers
  task automatic add_byte(input logic [7:0] b, input bit fast = 1'b0);
    rx_item_t item;
    item.data = b;
    item.fast = fast;
    rx_backlog.push_back(item);
  endtask

  task automatic add_frame(input logic [7:0] ftype, input logic [7:0] sub,
                           input logic [15:0] value, input bit bad_check = 1'b0);
    logic [7:0] chk;
    chk = value[7:0] ^ value[15:8] ^ sub;
    if (bad_check) chk = chk ^ 8'($urandom_range(1, 255));
    add_byte(HdrByte);
    add_byte(ftype);
    add_byte(sub);
    add_byte(value[15:8]);
    add_byte(value[7:0]);
    add_byte(chk);
  endtask

  // random frame with mostly known codes, plus noise and damaged frames
  task automatic add_random_chunk();
    int unsigned pick, len;
    logic [7:0]  ftype, sub;
    logic [15:0] value;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      len = $urandom_range(1, 4);
      repeat (len) add_byte(($urandom_range(0, 3) == 0) ? HdrByte : 8'($urandom));
    end else begin
      case ($urandom_range(0, 9))
        0:       ftype = ($urandom_range(0, 1) != 0) ? TypeOther : 8'($urandom);
        1, 2, 3: ftype = TypeGain;
        default: ftype = TypeDir;
      endcase
      if ($urandom_range(0, 9) == 0) begin
        sub = 8'($urandom);
      end else if (ftype == TypeGain) begin
        sub = 8'($urandom_range(SUB_GAIN_SCALE, SUB_GAIN_P));
        // keep the scale near its usual size most of the time
        if (sub == SUB_GAIN_SCALE && $urandom_range(0, 3) != 0) sub = SUB_GAIN_P;
      end else begin
        sub = 8'($urandom_range(SUB_DIR_STOP, SUB_DIR_HALT));
      end
      case ($urandom_range(0, 3))
        0:       value = 16'($urandom);
        1:       value = 16'($urandom_range(0, 255));
        2:       value = {8'($urandom), 8'hFF};
        default: value = 16'($urandom_range(0, 2000));
      endcase
      if (ftype == TypeGain && sub == SUB_GAIN_SCALE && $urandom_range(0, 1) != 0)
        value = 16'($urandom_range(50, 200));
      add_frame(ftype, sub, value, pick == 2);
    end
  endtask

  // chained trim frames: the check byte is the next header, one frame per five bytes
  task automatic add_trim_chain(input logic [7:0] sub, input int unsigned frames);
    logic [7:0] lo;
    lo = HdrByte ^ sub;
    repeat (frames) begin
      add_byte(HdrByte, 1'b1);
      add_byte(TypeDir, 1'b1);
      add_byte(sub, 1'b1);
      add_byte(8'h00, 1'b1);
      add_byte(lo, 1'b1);
    end
  endtask

  // clock
  initial begin
    forever #10ns clk_i = ~clk_i;
  end

  // sender: bytes from the backlog in bursts with random gaps, holding under full
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) decode_rx_byte(rx_byte_i);
      if (!(push && full)) begin
        if (rx_backlog.size() > 0 && (gap_left == 0 || rx_backlog[0].fast)) begin
          next_item = rx_backlog.pop_front();
          push      <= 1'b1;
          rx_byte_i <= next_item.data;
          fast_mode <= next_item.fast;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 12);
            gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 7);
          end
        end else begin
          push      <= 1'b0;
          rx_byte_i <= 8'($urandom);
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // receiver: stall pattern picks a new mode each time its random run ends
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(8, 64);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0:       pop <= 1'b1;
        1:       pop <= fast_mode || $urandom_range(0, 3) != 0;
        2:       pop <= fast_mode || $urandom_range(0, 3) == 0;
        default: pop <= fast_mode || $urandom_range(0, 1) != 0;
      endcase
    end
  end

  // monitor: each result transfer against the oldest predicted status
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (status_reports.size() == 0) begin
        $error("result transfer with no status predicted");
        fail_count++;
      end else begin
        check_field("frame_ok", status_reports[0].ok, frame_ok_o);
        check_field("frame_kind", status_reports[0].kind, frame_kind_o);
        check_field("speed_demand", status_reports[0].state.speed, speed_demand_o);
        check_field("turn_demand", status_reports[0].state.turn, turn_demand_o);
        check_field("trim_tenths", status_reports[0].state.trim, trim_tenths_o);
        check_field("gain_p", status_reports[0].state.gain_p, gain_p_o);
        check_field("gain_i", status_reports[0].state.gain_i, gain_i_o);
        check_field("gain_d", status_reports[0].state.gain_d, gain_d_o);
        check_field("wheel_gain", status_reports[0].state.wheel_gain, wheel_gain_o);
        check_field("gain_scale", status_reports[0].state.gain_scale, gain_scale_o);
        check_field("running", status_reports[0].state.running, running_o);
        void'(status_reports.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[command_frame_decoder_unit] ERROR");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin
    recent_rx = '0;
    dec_state.speed      = '0;
    dec_state.turn       = '0;
    dec_state.trim       = '0;
    dec_state.gain_p     = 26'd4000;
    dec_state.gain_i     = 26'd500;
    dec_state.gain_d     = 26'd40;
    dec_state.wheel_gain = 16'd1500;
    dec_state.gain_scale = 16'd100;
    dec_state.running    = 1'b0;

    // directed: extreme gains, every subcommand, unknown codes, a bad check
    add_frame(TypeGain, SUB_GAIN_SCALE, 16'hFFFF);
    add_frame(TypeGain, SUB_GAIN_P, 16'hFFFF);
    add_frame(TypeGain, SUB_GAIN_I, 16'h0000);
    add_frame(TypeGain, SUB_GAIN_SCALE, 16'h0000);
    add_frame(TypeGain, SUB_GAIN_D, 16'd1234);
    add_frame(TypeGain, SUB_GAIN_SCALE, 16'd100);
    add_frame(TypeGain, SUB_GAIN_D, 16'd99);
    add_frame(TypeGain, SUB_GAIN_WHEEL, 16'hFFFF);
    add_frame(TypeGain, SUB_GAIN_WHEEL, 16'h0000);
    add_frame(TypeGain, SubUnknown, 16'h5A5A);
    add_frame(TypeDir, SUB_DIR_START, 16'h0000);
    add_frame(TypeDir, SUB_DIR_FWD, 16'h00FF);
    add_frame(TypeDir, SUB_DIR_LEFT, 16'hFFFF);
    add_frame(TypeDir, SUB_DIR_BACK, 16'h00FF);
    add_frame(TypeDir, SUB_DIR_RIGHT, 16'h00FF);
    add_frame(TypeDir, SUB_DIR_HALT, 16'h0000);
    add_frame(TypeDir, SUB_DIR_TRIM_UP, 16'h0000);
    add_frame(TypeDir, SUB_DIR_TRIM_DN, 16'h0000);
    add_frame(TypeDir, SUB_DIR_TRIM_DN, 16'h0000);
    add_frame(TypeDir, SUB_DIR_FWD, 16'h0080);
    add_frame(TypeDir, SUB_DIR_STOP, 16'h0000);
    add_frame(TypeDir, SubUnknown, 16'h1234);
    add_frame(TypeOther, SUB_DIR_FWD, 16'h0011);
    add_frame(TypeDir, SUB_DIR_FWD, 16'h0033, 1'b1);

    // random frame streams
    while (rx_backlog.size() < 450) add_random_chunk();

    // chained trim frames up, then down past zero
    add_trim_chain(SUB_DIR_TRIM_UP, 12);
    add_trim_chain(SUB_DIR_TRIM_DN, 24);
    add_byte(HdrByte, 1'b1);
    add_frame(TypeDir, SUB_DIR_TRIM_UP, 16'h0000);
    repeat (10) add_random_chunk();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rx_backlog.size() > 0 || push || status_reports.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (status_reports.size() > 0) begin
      $error("%0d predicted results never arrived", status_reports.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[command_frame_decoder_unit] OK");
    end else begin
      $display("[command_frame_decoder_unit] ERROR");
    end
    $finish;
  end

endmodule
